// ===== src/atcb_pkg.sv =====
`timescale 1ns / 1ps

package atcb_pkg;

    localparam int BUDGET_W = 16;
    localparam int MODE_W = 3;
    localparam int MIN_W = 11;
    localparam int ACTION_W = 2;
    localparam int WEIGHT_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ACTION_W-1:0] ACT_REBOOT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TASK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLOW = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
    localparam logic [MODE_W-1:0] MODE_VALLEY = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FAST_AWARE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_VALLEY_AWARE = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_ADAPT_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FLOOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TARGET = 2'd2;

    localparam logic [MODE_W-1:0] RESET_MODE = MODE_FAST;
    localparam logic [MIN_W-1:0] RESET_TARGET_FLOOR = 11'd2;
    localparam logic [BUDGET_W-1:0] RESET_MAX_TARGET = 16'h0400;
    localparam logic [BUDGET_W-1:0] RESET_TARGET = 16'd1;
    localparam logic [BUDGET_W-1:0] RESET_RUNNING = 16'd0;
    localparam logic [BUDGET_W-1:0] RESET_HISTORY = 16'd10;

    typedef struct packed {
        logic [BUDGET_W-1:0] target;
        logic [BUDGET_W-1:0] running;
        logic [BUDGET_W-1:0] history;
    } budget_state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MIN_W-1:0] target_floor;
        logic [BUDGET_W-1:0] max_target;
    } budget_cfg_t;

endpackage

// ===== src/atcb_update.sv =====
`timescale 1ns / 1ps

module atcb_update
    import atcb_pkg::*;
(
    input  budget_state_t       state,
    input  budget_cfg_t         cfg,
    input  logic [ACTION_W-1:0] action,
    input  logic [WEIGHT_W-1:0] task_weight,
    output budget_state_t       state_next,
    output logic                due
);

    logic                is_fast;
    logic                is_valley;
    logic                is_aware;
    logic [BUDGET_W-1:0] step;
    logic [BUDGET_W-1:0] half_history_plus;
    logic [BUDGET_W-1:0] min_ext;
    logic [BUDGET_W-1:0] valley_half;
    logic [BUDGET_W:0]   commit_target;
    logic [BUDGET_W-1:0] running_sum;

    always_comb
    begin
        is_fast = (cfg.mode == MODE_FAST) || (cfg.mode == MODE_FAST_AWARE);
        is_valley = (cfg.mode == MODE_VALLEY) || (cfg.mode == MODE_VALLEY_AWARE);
        is_aware = (cfg.mode == MODE_FAST_AWARE) || (cfg.mode == MODE_VALLEY_AWARE);
        step = is_aware ? {{(BUDGET_W-WEIGHT_W){1'b0}}, task_weight}
                        : {{(BUDGET_W-1){1'b0}}, 1'b1};
        half_history_plus = (state.history >> 1) + {{(BUDGET_W-1){1'b0}}, 1'b1};
        min_ext = {{(BUDGET_W-MIN_W){1'b0}}, cfg.target_floor};
        valley_half = state.target >> 1;
        running_sum = state.running + step;

        // Candidate target for a commit, one bit wider so that slow mode can overflow.
        commit_target = {1'b0, state.target};
        if (cfg.mode == MODE_SLOW)
        begin
            commit_target = {1'b0, state.target} + {{BUDGET_W{1'b0}}, 1'b1};
        end
        else if (is_fast)
        begin
            commit_target = {1'b0, half_history_plus};
        end
        else if (is_valley)
        begin
            if (state.target > min_ext)
            begin
                commit_target = (valley_half < min_ext) ? {1'b0, min_ext}
                                                        : {1'b0, valley_half};
            end
        end
        if (commit_target > {1'b0, cfg.max_target})
        begin
            commit_target = {1'b0, cfg.max_target};
        end

        state_next = state;
        due = 1'b0;
        case (action)
            ACT_REBOOT:
            begin
                if (cfg.mode == MODE_SLOW)
                begin
                    if (state.target > {{(BUDGET_W-1){1'b0}}, 1'b1})
                    begin
                        state_next.target = state.target - {{(BUDGET_W-1){1'b0}}, 1'b1};
                    end
                end
                else if (is_fast || is_valley)
                begin
                    state_next.target = half_history_plus;
                end
                state_next.history = '0;
                state_next.running = '0;
            end
            ACT_TASK:
            begin
                state_next.running = running_sum;
                state_next.history = state.history + step;
                due = (running_sum >= state.target);
            end
            ACT_COMMIT:
            begin
                state_next.target = commit_target[BUDGET_W-1:0];
                state_next.running = '0;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ===== src/adaptive_task_coalescing_budget.sv =====
`timescale 1ns / 1ps

// Adaptive coalescing budget controller. Each input word is one event (reboot, task done with
// its weight, or commit done) and produces exactly one output word carrying commit_due and the
// target, running and history budgets after that event. An accepted word is held in an input
// register and is processed in the single cycle in which it moves to the output register, so
// the block takes one word per clock; only the output stall slows it down. Users must write
// configuration via the write port while no word is in flight; the block does not enforce it.

module adaptive_task_coalescing_budget
    import atcb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ACTION_W-1:0]    action,
    input  logic [WEIGHT_W-1:0]    task_weight,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   commit_due,
    output logic [BUDGET_W-1:0]    target_now,
    output logic [BUDGET_W-1:0]    running_now,
    output logic [BUDGET_W-1:0]    history_now
);

    budget_cfg_t         cfg_reg;
    budget_state_t       state_reg;
    budget_state_t       state_next;
    logic                due_next;

    logic                s1_valid_reg;
    logic [ACTION_W-1:0] s1_action_reg;
    logic [WEIGHT_W-1:0] s1_weight_reg;

    logic                out_valid_reg;
    logic                due_reg;
    budget_state_t       out_state_reg;

    logic                out_free;
    logic                advance;
    logic                in_accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    atcb_update u_update
    (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .action      (s1_action_reg),
        .task_weight (s1_weight_reg),
        .state_next  (state_next),
        .due         (due_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode <= RESET_MODE;
            cfg_reg.target_floor <= RESET_TARGET_FLOOR;
            cfg_reg.max_target <= RESET_MAX_TARGET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ADAPT_MODE: cfg_reg.mode <= cfg_data[MODE_W-1:0];
                REG_TARGET_FLOOR: cfg_reg.target_floor <= cfg_data[MIN_W-1:0];
                REG_MAX_TARGET: cfg_reg.max_target <= cfg_data[BUDGET_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.target <= RESET_TARGET;
            state_reg.running <= RESET_RUNNING;
            state_reg.history <= RESET_HISTORY;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_weight_reg <= task_weight;
        end
        if (advance)
        begin
            due_reg <= due_next;
            out_state_reg <= state_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign commit_due = due_reg;
    assign target_now = out_state_reg.target;
    assign running_now = out_state_reg.running;
    assign history_now = out_state_reg.history;

endmodule

// ===== bench/adaptive_task_coalescing_budget_test.sv =====
`timescale 1ns / 1ps

module adaptive_task_coalescing_budget_test;
    import atcb_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES = 12;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE_LOW = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HIGH = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WEIGHT_W-1:0] weight;
    } budget_event_t;

    typedef struct packed {
        logic                due;
        logic [BUDGET_W-1:0] target;
        logic [BUDGET_W-1:0] running;
        logic [BUDGET_W-1:0] history;
    } budget_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action = '0;
    logic [WEIGHT_W-1:0]    task_weight = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   commit_due;
    logic [BUDGET_W-1:0]    target_now;
    logic [BUDGET_W-1:0]    running_now;
    logic [BUDGET_W-1:0]    history_now;

    budget_event_t  pending_events[$];
    budget_result_t expected_budgets[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int errors = 0;

    logic [MODE_W-1:0]   cur_mode = RESET_MODE;
    logic [MIN_W-1:0]    cur_min = RESET_TARGET_FLOOR;
    logic [BUDGET_W-1:0] cur_max = RESET_MAX_TARGET;

    logic [BUDGET_W-1:0] pred_target = RESET_TARGET;
    logic [BUDGET_W-1:0] pred_running = RESET_RUNNING;
    logic [BUDGET_W-1:0] pred_history = RESET_HISTORY;

    adaptive_task_coalescing_budget i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .task_weight (task_weight),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .commit_due  (commit_due),
        .target_now  (target_now),
        .running_now (running_now),
        .history_now (history_now)
    );

    always #1 clk = ~clk;

    function automatic budget_result_t advance_budget(input logic [ACTION_W-1:0] act,
                                                      input logic [WEIGHT_W-1:0] wt);
        budget_result_t      r;
        logic [BUDGET_W:0]   next_target;
        logic [BUDGET_W-1:0] step;
        logic                fast_mode;
        logic                valley_mode;
        logic                aware_mode;
        fast_mode = (cur_mode == MODE_FAST) || (cur_mode == MODE_FAST_AWARE);
        valley_mode = (cur_mode == MODE_VALLEY) || (cur_mode == MODE_VALLEY_AWARE);
        aware_mode = (cur_mode == MODE_FAST_AWARE) || (cur_mode == MODE_VALLEY_AWARE);
        r.due = 1'b0;
        case (act)
            ACT_REBOOT:
            begin
                if (cur_mode == MODE_SLOW)
                begin
                    if (pred_target > 16'd1)
                        pred_target = pred_target - 16'd1;
                end
                else if (fast_mode || valley_mode)
                    pred_target = (pred_history >> 1) + 16'd1;
                pred_history = '0;
                pred_running = '0;
            end
            ACT_TASK:
            begin
                step = aware_mode ? {8'd0, wt} : 16'd1;
                pred_running = pred_running + step;
                pred_history = pred_history + step;
                r.due = (pred_running >= pred_target);
            end
            ACT_COMMIT:
            begin
                next_target = {1'b0, pred_target};
                if (cur_mode == MODE_SLOW)
                    next_target = next_target + 17'd1;
                else if (fast_mode)
                    next_target = {1'b0, pred_history >> 1} + 17'd1;
                else if (valley_mode)
                begin
                    if (next_target > {6'd0, cur_min})
                    begin
                        next_target = next_target >> 1;
                        if (next_target < {6'd0, cur_min})
                            next_target = {6'd0, cur_min};
                    end
                end
                if (next_target > {1'b0, cur_max})
                    next_target = {1'b0, cur_max};
                pred_target = next_target[BUDGET_W-1:0];
                pred_running = '0;
            end
            default:
            begin
            end
        endcase
        r.target = pred_target;
        r.running = pred_running;
        r.history = pred_history;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [BUDGET_W-1:0] want,
                                        input logic [BUDGET_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Sender: a word is only replaced once it has been taken, so valid never follows stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                action <= pending_events[0].action;
                task_weight <= pending_events[0].weight;
                void'(pending_events.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_stall <= 1'b1;
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        budget_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_budgets.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual due %0b target %0d",
                             $time, commit_due, target_now);
                    errors++;
                end
                else
                begin
                    want = expected_budgets.pop_front();
                    check_field("commit_due", {15'd0, want.due}, {15'd0, commit_due});
                    check_field("target_now", want.target, target_now);
                    check_field("running_now", want.running, running_now);
                    check_field("history_now", want.history, history_now);
                end
            end
            if (in_valid && !in_stall)
                expected_budgets.push_back(advance_budget(action, task_weight));
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("adaptive_task_coalescing_budget_test: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_budgets.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ADAPT_MODE: cur_mode = data[MODE_W-1:0];
            REG_TARGET_FLOOR: cur_min = data[MIN_W-1:0];
            REG_MAX_TARGET: cur_max = data;
            default:
            begin
            end
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_cfg(input budget_cfg_t c);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'($urandom());
        d[MODE_W-1:0] = c.mode;
        write_reg(REG_ADAPT_MODE, d);
        d = CFG_DATA_W'($urandom());
        d[MIN_W-1:0] = c.target_floor;
        write_reg(REG_TARGET_FLOOR, d);
        write_reg(REG_MAX_TARGET, c.max_target);
    endtask

    task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [WEIGHT_W-1:0] wt);
        budget_event_t e;
        e.action = act;
        e.weight = wt;
        pending_events.push_back(e);
    endtask

    // Mostly runs of tasks broken by commits; heavy runs use big weights, never reboot and almost
    // never commit, so the history and running budgets wrap.
    task automatic queue_random(input int count, input bit heavy);
        int                  roll;
        int                  reboot_pm;
        int                  commit_pm;
        int                  unknown_pm;
        logic [ACTION_W-1:0] act;
        logic [WEIGHT_W-1:0] wt;
        reboot_pm = heavy ? 0 : 60;
        commit_pm = heavy ? 3 : 140;
        unknown_pm = heavy ? 2 : 20;
        repeat (count)
        begin
            roll = int'($urandom_range(999));
            if (roll < reboot_pm)
                act = ACT_REBOOT;
            else if (roll < reboot_pm + commit_pm)
                act = ACT_COMMIT;
            else if (roll < reboot_pm + commit_pm + unknown_pm)
                act = ACT_UNKNOWN;
            else
                act = ACT_TASK;
            roll = int'($urandom_range(99));
            if (heavy)
                wt = WEIGHT_W'($urandom_range(255, 192));
            else if (roll < 5)
                wt = '0;
            else if (roll < 10)
                wt = '1;
            else
                wt = WEIGHT_W'($urandom_range(255));
            queue_word(act, wt);
        end
    endtask

    initial
    begin : stimulus
        budget_cfg_t phase_cfg[NUM_PHASES];
        int          p;
        phase_cfg[0] = '{MODE_NONE, 11'd2, 16'd1024};
        phase_cfg[1] = '{MODE_SLOW, 11'd1, 16'd32768};
        phase_cfg[2] = '{MODE_FAST, 11'd2, 16'd1};
        phase_cfg[3] = '{MODE_VALLEY, 11'd1024, 16'd32768};
        phase_cfg[4] = '{MODE_FAST_AWARE, 11'd1, 16'hFFFF};
        phase_cfg[5] = '{MODE_VALLEY_AWARE, 11'h7FF, 16'd0};
        phase_cfg[6] = '{MODE_SPARE_HIGH, 11'd5, 16'd100};
        phase_cfg[7] = '{MODE_VALLEY, 11'd0, 16'hFFFF};
        phase_cfg[8] = '{MODE_SLOW, 11'd2, 16'd3};
        phase_cfg[9] = '{MODE_FAST_AWARE, 11'd2, 16'd0};
        phase_cfg[10] = '{MODE_W'($urandom()), MIN_W'($urandom()), BUDGET_W'($urandom())};
        phase_cfg[11] = '{MODE_SPARE_LOW, 11'd1, 16'd20};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: fast adaptation from the initial history.
        queue_word(ACT_TASK, 8'd0);
        queue_word(ACT_TASK, 8'd255);
        queue_word(ACT_COMMIT, 8'd0);
        queue_word(ACT_TASK, 8'd128);
        queue_word(ACT_TASK, 8'd1);
        queue_word(ACT_TASK, 8'd254);
        queue_word(ACT_UNKNOWN, 8'd255);
        queue_word(ACT_REBOOT, 8'd0);
        queue_word(ACT_TASK, 8'd170);
        queue_word(ACT_TASK, 8'd85);
        queue_word(ACT_COMMIT, 8'd255);
        queue_word(ACT_COMMIT, 8'd0);
        queue_word(ACT_REBOOT, 8'd255);
        queue_word(ACT_REBOOT, 8'd0);
        queue_word(ACT_TASK, 8'd255);
        queue_word(ACT_TASK, 8'd0);
        queue_word(ACT_UNKNOWN, 8'd0);
        queue_word(ACT_COMMIT, 8'd0);
        queue_word(ACT_TASK, 8'd7);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
            apply_cfg(phase_cfg[p]);
            @(negedge clk);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 74;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 74;
                end
                default:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            if (p == 4)
            begin
                hold_requests++;
                queue_random(300, 1'b1);
            end
            else
                queue_random(60, 1'b0);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_budgets.size() == 0)
            $display("adaptive_task_coalescing_budget_test: done, clean");
        else
            $display("adaptive_task_coalescing_budget_test: done, errors");
        $finish;
    end

endmodule
